### src/keyed_max_height_table_assert.svh
// Assertion macros shared by the checker files of the keyed max height table.
// Every macro samples on clk and is disabled while rst is high.
`ifndef KEYED_MAX_HEIGHT_TABLE_ASSERT_SVH
`define KEYED_MAX_HEIGHT_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KMHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed_max_height_table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define KMHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed_max_height_table assertion failed");

`endif

### src/kmht_pkg.sv
// Package for the keyed max height table: sizes, entry layout and operation codes.
// No dependencies; the table top level and its checker import it.
package kmht_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 160;
  localparam int HEIGHT_W = 63;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_BUMP   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HEIGHT_W-1:0] height;
  } entry_t;

endpackage

### src/kmht_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Generic; used by the keyed max height table for its entry store.
module kmht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/keyed_max_height_table.sv
// Keyed max height table: maps 160-bit owner keys to a monotonic 63-bit height. One
// transaction is handled at a time. After acceptance the entry RAM is scanned one entry
// per cycle through its single read port. A hit goes to S_PUSH; a miss (the scan ends,
// or the table is empty) goes through S_MISS to S_PUSH, which offers the registered result
// once the output is free. The input is free again in the same cycle the result is
// offered, and the next transaction can be taken while that result waits. Lookups return
// the stored height, bumps keep the larger height or append a new entry, and a bump that
// needs a new entry in a full table raises table_full and leaves the table unchanged.
module keyed_max_height_table
  import kmht_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [63:0]         owner_hi,
  input  logic [63:0]         owner_mid,
  input  logic [31:0]         owner_lo,
  input  logic [HEIGHT_W-1:0] new_height,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [HEIGHT_W-1:0] stored_height,
  output logic                found,
  output logic                table_full
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MISS = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [CNT_W-1:0]    count;
  logic [IDX_W-1:0]    scan_idx;
  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [HEIGHT_W-1:0] res_height;
  logic                res_found;
  logic                res_full;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;
  logic [IDX_W-1:0]    raddr;
  entry_t              rdata;

  logic                accept;
  logic                hit;
  logic                last;
  logic                raise;
  logic                room;
  logic                out_free;

  kmht_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hit      = (rdata.key == key_q);
  assign last     = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);
  assign raise    = (op_q == OP_BUMP) && (height_q > rdata.height);
  assign room     = (count < CNT_W'(ENTRIES));

  // Entry 0 is fetched while the transaction is accepted, so the scan compares every cycle.
  assign raddr = (state == S_SCAN) ? scan_idx + IDX_W'(1) : '0;

  always_comb begin
    we         = 1'b0;
    waddr      = scan_idx;
    wdata.key    = key_q;
    wdata.height = height_q;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (count == '0) ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          we         = raise;
          state_next = S_PUSH;
        end else if (last) begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        we         = (op_q == OP_BUMP) && room;
        waddr      = count[IDX_W-1:0];
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_MISS && we) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      key_q    <= {owner_hi, owner_mid, owner_lo};
      height_q <= new_height;
      scan_idx <= '0;
    end else if (state == S_SCAN && !hit && !last) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == S_SCAN && hit) begin
      res_height <= raise ? height_q : rdata.height;
      res_found  <= 1'b1;
      res_full   <= 1'b0;
    end
    if (state == S_MISS) begin
      res_found <= 1'b0;
      if (op_q == OP_BUMP && room) begin
        res_height <= height_q;
        res_full   <= 1'b0;
      end else begin
        res_height <= '0;
        res_full   <= (op_q == OP_BUMP);
      end
    end
    if (state == S_PUSH && out_free) begin
      stored_height <= res_height;
      found         <= res_found;
      table_full    <= res_full;
    end
  end

endmodule

### src/kmht_checker.sv
// Port-level checker for the keyed max height table, bound to the top level.
// Depends on kmht_pkg and the assertion macros in keyed_max_height_table_assert.svh.
`include "keyed_max_height_table_assert.svh"

module kmht_checker
  import kmht_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                op,
  input logic [63:0]         owner_hi,
  input logic [63:0]         owner_mid,
  input logic [31:0]         owner_lo,
  input logic [HEIGHT_W-1:0] new_height,
  input logic                out_valid,
  input logic                out_stall,
  input logic [HEIGHT_W-1:0] stored_height,
  input logic                found,
  input logic                table_full
);

  // A stalled result stays offered and unchanged.
  `KMHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(stored_height) && $stable(found) && $stable(table_full))

  // The block works on one transaction at a time.
  `KMHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // A dropped insert reports an absent key with no height.
  `KMHT_ASSERT_NOW(a_full_is_miss, out_valid && table_full, !found && stored_height == '0)

  // A present key never reports a full table.
  `KMHT_ASSERT_NOW(a_found_not_full, out_valid && found, !table_full)

endmodule

bind keyed_max_height_table kmht_checker u_kmht_checker (.*);
